FILE: src/color_bitmap_expand_histogram_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for color_bitmap_expand_histogram
// Implication checks on the rising clock edge, off while reset is low.
// ----------------------------------------------------------------------------
`ifndef COLOR_BITMAP_EXPAND_HISTOGRAM_ASSERT_SVH
`define COLOR_BITMAP_EXPAND_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CBEH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbeh: implication check failed");
// next-cycle implication
`define CBEH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbeh: next-cycle check failed");
`else
`define CBEH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CBEH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cbeh_pkg.sv
// ----------------------------------------------------------------------------
// cbeh_pkg
// Shared types and constants of the color bitmap expander.
// ----------------------------------------------------------------------------
`default_nettype none

package cbeh_pkg;

    localparam int WORD_W      = 64;
    localparam int CFG_W       = 5;
    localparam int BIN_IDX_W   = 11;
    localparam int COLOR_IDX_W = 10;
    localparam int CNT_OUT_W   = 11;
    localparam int BINCNT_W    = 48;
    localparam int BITPOS_W    = 6;
    localparam int WPOS_W      = 6;   // word position inside a record, up to 64 words
    localparam int HIST_AW_MAX = 13;  // address bits for the largest histogram
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_KEY  = 2'd0;
    localparam t_kind KIND_BITS = 2'd1;
    localparam t_kind KIND_READ = 2'd2;

    localparam logic OP_WORD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // classified item between front and back
    typedef struct packed {
        t_kind               kind;
        logic [WORD_W-1:0]   data;     // key, bitmap, or bin index
        logic [WPOS_W-1:0]   wpos;
        logic                rec_end;
    } t_entry;

    typedef struct packed {
        logic                   color_valid;
        logic [COLOR_IDX_W-1:0] color_index;
        logic                   record_end;
        logic [WORD_W-1:0]      record_key;
        logic [CNT_OUT_W-1:0]   record_color_count;
        logic [BINCNT_W-1:0]    bin_count;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic    valid;
        logic    bin_read;
        logic    in_range;
        t_result res;
    } t_issue;

    typedef struct packed {
        logic                   valid;
        logic                   inc;
        logic [HIST_AW_MAX-1:0] addr;
    } t_hist_req;

endpackage

`default_nettype wire

FILE: src/cbeh_fifo.sv
// ----------------------------------------------------------------------------
// cbeh_fifo
// Small register queue with occupancy count; push and pop in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbeh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_din,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_dout,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [IW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_dout  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == IW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == IW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

endmodule

`default_nettype wire

FILE: src/cbeh_front.sv
// ----------------------------------------------------------------------------
// cbeh_front
// Accepts input words, tracks the record position and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module cbeh_front
    import cbeh_pkg::*;
#(
    parameter int MAX_COLOR_WORDS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_operation,
    input  wire logic [WORD_W-1:0]    i_data_word,
    input  wire logic [BIN_IDX_W-1:0] i_bin_index,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output t_entry                    o_entry
);

    localparam int PW = $clog2(MAX_COLOR_WORDS+1);

    logic [CFG_W-1:0] r_color_words;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    eff_words;
    logic             rec_end;

    // clamp the register into 1..MAX_COLOR_WORDS
    always_comb begin
        if (r_color_words == '0) begin
            eff_words = PW'(1);
        end else if (32'(r_color_words) > MAX_COLOR_WORDS) begin
            eff_words = PW'(MAX_COLOR_WORDS);
        end else begin
            eff_words = PW'(r_color_words);
        end
    end

    assign rec_end = (32'(r_wp) >= 32'(eff_words));

    always_comb begin
        o_entry.data    = i_data_word;
        o_entry.wpos    = WPOS_W'(32'(r_wp) - 32'd1);
        o_entry.rec_end = rec_end;
        n_wp            = r_wp;
        if (i_operation == OP_READ) begin
            o_entry.kind = KIND_READ;
            o_entry.data = WORD_W'(i_bin_index);
        end else if (r_wp == '0) begin
            o_entry.kind = KIND_KEY;
            n_wp         = PW'(1);
        end else begin
            o_entry.kind = KIND_BITS;
            n_wp         = rec_end ? '0 : r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_words <= CFG_W'(1);
            r_wp          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_color_words <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_wp <= n_wp;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/cbeh_back.sv
// ----------------------------------------------------------------------------
// cbeh_back
// Scans bitmap words one set bit per cycle while result credit is given,
// keeps the record count and key, and issues results and histogram requests.
// ----------------------------------------------------------------------------
`default_nettype none

module cbeh_back
    import cbeh_pkg::*;
#(
    parameter int MAX_COLOR_WORDS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head_valid,
    input  wire t_entry i_head,
    input  wire logic   i_credit,
    output logic        o_pop,
    output t_issue      o_issue,
    output t_hist_req   o_hreq
);

    localparam int NUM_BINS = MAX_COLOR_WORDS * 64 + 1;
    localparam int CNT_W    = $clog2(NUM_BINS);

    logic [WORD_W-1:0]   r_done, n_done;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [WORD_W-1:0]   r_key, n_key;
    logic [WORD_W-1:0]   cur, low_bit, rest;
    logic [BITPOS_W-1:0] bit_pos;
    logic [CNT_W-1:0]    cnt_inc;

    assign cur     = i_head.data & ~r_done;
    assign low_bit = cur & (~cur + 1'b1);
    assign rest    = cur & ~low_bit;
    assign cnt_inc = r_count + 1'b1;

    always_comb begin
        bit_pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (low_bit[i]) begin
                bit_pos = bit_pos | BITPOS_W'(i);
            end
        end
    end

    always_comb begin
        o_pop      = 1'b0;
        o_issue    = '0;
        o_hreq     = '0;
        n_done     = r_done;
        n_count    = r_count;
        n_key      = r_key;
        if (i_head_valid) begin
            unique case (i_head.kind)
                KIND_KEY: begin
                    o_pop   = 1'b1;
                    n_key   = i_head.data;
                    n_count = '0;
                end
                KIND_READ: begin
                    if (i_credit) begin
                        o_pop            = 1'b1;
                        o_issue.valid    = 1'b1;
                        o_issue.bin_read = 1'b1;
                        o_issue.in_range = (32'(i_head.data[BIN_IDX_W-1:0]) < NUM_BINS);
                        o_issue.res.last = 1'b1;
                        o_hreq.valid     = 1'b1;
                        o_hreq.addr      = HIST_AW_MAX'(i_head.data[BIN_IDX_W-1:0]);
                    end
                end
                KIND_BITS: begin
                    if (cur == '0) begin
                        // empty word: only the record end gives a result
                        if (!i_head.rec_end) begin
                            o_pop  = 1'b1;
                            n_done = '0;
                        end else if (i_credit) begin
                            o_pop                         = 1'b1;
                            n_done                        = '0;
                            o_issue.valid                 = 1'b1;
                            o_issue.res.record_end        = 1'b1;
                            o_issue.res.record_key        = r_key;
                            o_issue.res.record_color_count = CNT_OUT_W'(r_count);
                            o_issue.res.last              = 1'b1;
                            o_hreq.valid                  = 1'b1;
                            o_hreq.inc                    = 1'b1;
                            o_hreq.addr                   = HIST_AW_MAX'(r_count);
                        end
                    end else if (i_credit) begin
                        o_issue.valid           = 1'b1;
                        o_issue.res.color_valid = 1'b1;
                        o_issue.res.color_index = {i_head.wpos[3:0], bit_pos};
                        n_count                 = cnt_inc;
                        if (rest == '0) begin
                            o_pop            = 1'b1;
                            n_done           = '0;
                            o_issue.res.last = 1'b1;
                            if (i_head.rec_end) begin
                                o_issue.res.record_end         = 1'b1;
                                o_issue.res.record_key         = r_key;
                                o_issue.res.record_color_count = CNT_OUT_W'(cnt_inc);
                                o_hreq.valid                   = 1'b1;
                                o_hreq.inc                     = 1'b1;
                                o_hreq.addr                    = HIST_AW_MAX'(cnt_inc);
                            end
                        end else begin
                            n_done = r_done | low_bit;
                        end
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_count <= '0;
        end else begin
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

FILE: src/cbeh_hist.sv
// ----------------------------------------------------------------------------
// cbeh_hist
// Histogram memory: clearing sweep after reset, saturating read-modify-write
// increments and bin reads, with forwarding of the last write.
// ----------------------------------------------------------------------------
`default_nettype none

module cbeh_hist
    import cbeh_pkg::*;
#(
    parameter int MAX_COLOR_WORDS = 16,
    parameter int BIN_COUNT_BITS  = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_hist_req            i_req,
    output logic [BIN_COUNT_BITS-1:0] o_rd_data,
    output logic                      o_busy
);

    localparam int NUM_BINS = MAX_COLOR_WORDS * 64 + 1;
    localparam int HA       = $clog2(NUM_BINS);

    logic [BIN_COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [BIN_COUNT_BITS-1:0] r_rd;
    logic                      r_clr;
    logic [HA-1:0]             r_clr_addr;
    logic                      r_s1_inc;
    logic [HA-1:0]             r_s1_addr;
    logic                      r_lw_valid;
    logic [HA-1:0]             r_lw_addr;
    logic [BIN_COUNT_BITS-1:0] r_lw_data;
    logic [BIN_COUNT_BITS-1:0] cur;
    logic [BIN_COUNT_BITS-1:0] sat_inc;
    logic [HA-1:0]             req_addr;

    assign req_addr  = i_req.addr[HA-1:0];
    assign o_busy    = r_clr;
    // the bin written last cycle was not yet visible to this read
    assign cur       = (r_lw_valid && (r_lw_addr == r_s1_addr)) ? r_lw_data : r_rd;
    assign sat_inc   = (cur == '1) ? cur : cur + 1'b1;
    assign o_rd_data = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_s1_inc   <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == HA'(NUM_BINS-1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_s1_inc   <= i_req.valid && i_req.inc;
            r_lw_valid <= r_s1_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= req_addr;
        r_lw_addr <= r_s1_addr;
        r_lw_data <= sat_inc;
        r_rd      <= r_mem[req_addr];
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_s1_inc) begin
            r_mem[r_s1_addr] <= sat_inc;
        end
    end

endmodule

`default_nettype wire

FILE: src/color_bitmap_expand_histogram.sv
// ----------------------------------------------------------------------------
// color_bitmap_expand_histogram
// Expands color bitmaps of fixed-size records into color indexes and keeps a
// saturating histogram of per-record color counts.
//
// Input queue side: present operation/data_word/bin_index with i_push; a
// transfer happens when i_push is high and o_full is low. Each record is a
// key word then color_words bitmap words; operation 1 reads one bin.
// Result queue side: while o_empty is low the oldest result is on the ports;
// i_pop with o_empty low completes the transfer.
// Key words go through at one item per cycle; histogram reads and bitmap
// words with at most one set bit do too while the output queue has room. A
// bitmap word with several set bits holds the bit scanner for one result per
// set bit, one per cycle. The first result of an item passes the mid queue,
// the result register and the output queue. After reset the histogram is
// swept to zero, one bin per cycle over MAX_COLOR_WORDS*64+1 bins (1025 by
// default); o_full stays high meanwhile. Configuration writes are taken at
// any time. When the result side stalls, the output queue and the 4-entry
// queue ahead of the scanner fill, then o_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_bitmap_expand_histogram_assert.svh"

module color_bitmap_expand_histogram
    import cbeh_pkg::*;
#(
    parameter int MAX_COLOR_WORDS = 16,
    parameter int BIN_COUNT_BITS  = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                   i_push,
    output logic                        o_full,
    input  wire logic                   i_operation,
    input  wire logic [WORD_W-1:0]      i_data_word,
    input  wire logic [BIN_IDX_W-1:0]   i_bin_index,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output logic                        o_color_valid,
    output logic [COLOR_IDX_W-1:0]      o_color_index,
    output logic                        o_record_end,
    output logic [WORD_W-1:0]           o_record_key,
    output logic [CNT_OUT_W-1:0]        o_record_color_count,
    output logic [BINCNT_W-1:0]         o_bin_count,
    output logic                        o_last
);

    localparam int OCW = $clog2(OUT_DEPTH+1);
    localparam int MCW = $clog2(MID_DEPTH+1);

    t_entry                    front_entry;
    t_entry                    mid_head;
    logic                      mid_full, mid_empty;
    logic [MCW-1:0]            mid_count;
    logic                      accept;
    logic                      back_pop;
    t_issue                    issue;
    t_hist_req                 hreq;
    logic                      hist_busy;
    logic [BIN_COUNT_BITS-1:0] hist_data;
    logic                      credit;

    logic                      r_s1_valid;
    logic                      r_s1_read;
    logic                      r_s1_in_range;
    t_result                   r_s1_res;
    t_result                   s1_out;
    t_result                   out_res;
    logic                      out_full;
    logic [OCW-1:0]            out_count;

    assign o_full = mid_full || hist_busy;
    assign accept = i_push && !o_full;

    cbeh_front #(
        .MAX_COLOR_WORDS (MAX_COLOR_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_data_word (i_data_word),
        .i_bin_index (i_bin_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_entry     (front_entry)
    );

    cbeh_fifo #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_din   (front_entry),
        .i_pop   (back_pop),
        .o_dout  (mid_head),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    // room for the result now in flight plus this one
    assign credit = (32'(out_count) + 32'(r_s1_valid)) < OUT_DEPTH;

    cbeh_back #(
        .MAX_COLOR_WORDS (MAX_COLOR_WORDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!mid_empty),
        .i_head       (mid_head),
        .i_credit     (credit),
        .o_pop        (back_pop),
        .o_issue      (issue),
        .o_hreq       (hreq)
    );

    cbeh_hist #(
        .MAX_COLOR_WORDS (MAX_COLOR_WORDS),
        .BIN_COUNT_BITS  (BIN_COUNT_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hreq),
        .o_rd_data (hist_data),
        .o_busy    (hist_busy)
    );

    // align results with the registered histogram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_read     <= issue.bin_read;
        r_s1_in_range <= issue.in_range;
        r_s1_res      <= issue.res;
    end

    always_comb begin
        s1_out = r_s1_res;
        if (r_s1_read && r_s1_in_range) begin
            s1_out.bin_count = BINCNT_W'(hist_data);
        end
    end

    cbeh_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_din   (s1_out),
        .i_pop   (i_pop),
        .o_dout  (out_res),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign o_color_valid        = out_res.color_valid;
    assign o_color_index        = out_res.color_index;
    assign o_record_end         = out_res.record_end;
    assign o_record_key         = out_res.record_key;
    assign o_record_color_count = out_res.record_color_count;
    assign o_bin_count          = out_res.bin_count;
    assign o_last               = out_res.last;

    `CBEH_ASSERT_IMPL(a_out_no_overflow, i_clk, i_rst_n, r_s1_valid, !out_full)
    `CBEH_ASSERT_IMPL(a_clear_blocks_input, i_clk, i_rst_n, hist_busy, o_full && mid_count == '0)
    `CBEH_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, !o_empty && o_record_end, o_last)
    `CBEH_ASSERT_NEXT(a_read_no_color, i_clk, i_rst_n, issue.valid && issue.bin_read, r_s1_valid && !r_s1_res.color_valid && !r_s1_res.record_end)

endmodule

`default_nettype wire

FILE: bench/tb_color_bitmap_expand_histogram.sv
// ----------------------------------------------------------------------------
// tb_color_bitmap_expand_histogram
// Self-checking bench for the color bitmap expander. Streams records and
// histogram bin reads through the input queue with random push/pop pacing,
// predicts every result from the record stream and the count histogram, and
// compares each popped result field by field, in order.
// ----------------------------------------------------------------------------
module tb_color_bitmap_expand_histogram;
    timeunit 1ns;
    timeprecision 1ps;

    import cbeh_pkg::*;

    localparam int          MAX_WORDS    = 16;
    localparam int          NUM_BINS     = MAX_WORDS * 64 + 1;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          PHASE_ITEMS  = 28;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   i_push;
    logic                   o_full;
    logic                   i_operation;
    logic [WORD_W-1:0]      i_data_word;
    logic [BIN_IDX_W-1:0]   i_bin_index;
    logic                   o_empty;
    logic                   i_pop;
    logic                   o_color_valid;
    logic [COLOR_IDX_W-1:0] o_color_index;
    logic                   o_record_end;
    logic [WORD_W-1:0]      o_record_key;
    logic [CNT_OUT_W-1:0]   o_record_color_count;
    logic [BINCNT_W-1:0]    o_bin_count;
    logic                   o_last;

    logic                   steady;       // no idle cycles on either side
    int unsigned            cycle_count;

    // Tracks record state and histogram, holds the results still owed.
    class color_expand_tracker;
        logic [CFG_W-1:0]    color_words;
        int unsigned         word_pos;
        int unsigned         run_count;
        logic [WORD_W-1:0]   key_hold;
        logic [BINCNT_W-1:0] hist [NUM_BINS];
        t_result             owed_results[$];
        int unsigned         mismatches;
        int unsigned         items;
        int unsigned         records;
        int unsigned         reads;
        int unsigned         results;
        int unsigned         cfg_writes;

        function new();
            color_words = 5'd1;
            word_pos    = 0;
            run_count   = 0;
            key_hold    = '0;
            foreach (hist[i]) hist[i] = '0;
            mismatches  = 0;
            items       = 0;
            records     = 0;
            reads       = 0;
            results     = 0;
            cfg_writes  = 0;
        endfunction

        function void note_item(logic op, logic [WORD_W-1:0] w, logic [BIN_IDX_W-1:0] b);
            t_result     batch[$];
            t_result     r;
            int unsigned eff;
            int unsigned slot;
            logic        closes;
            items++;
            if (op == OP_READ) begin
                reads++;
                r = '0;
                r.bin_count = (b < NUM_BINS) ? hist[b] : '0;
                r.last = 1'b1;
                owed_results.insert(owed_results.size(), r);
                return;
            end
            if (word_pos == 0) begin
                key_hold  = w;
                run_count = 0;
                word_pos  = 1;
                return;
            end
            eff = (color_words == 0) ? 1 : (color_words > MAX_WORDS) ? MAX_WORDS : color_words;
            closes = (word_pos >= eff);
            for (int i = 0; i < WORD_W; i++) begin
                if (w[i]) begin
                    r = '0;
                    r.color_valid = 1'b1;
                    r.color_index = COLOR_IDX_W'((word_pos - 1) * 64 + i);
                    batch.insert(batch.size(), r);
                    run_count++;
                end
            end
            if (closes) begin
                records++;
                slot = (run_count >= NUM_BINS) ? NUM_BINS - 1 : run_count;
                if (hist[slot] != '1) hist[slot] = hist[slot] + 1'b1;
                // empty final word still yields one end-of-record result
                if (batch.size() == 0) r = '0;
                else r = batch.pop_back();
                r.record_end         = 1'b1;
                r.record_key         = key_hold;
                r.record_color_count = CNT_OUT_W'(run_count);
                batch.insert(batch.size(), r);
                word_pos = 0;
            end else begin
                word_pos++;
            end
            if (batch.size() > 0) begin
                r = batch.pop_back();
                r.last = 1'b1;
                batch.insert(batch.size(), r);
            end
            foreach (batch[i]) owed_results.insert(owed_results.size(), batch[i]);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 results, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            results++;
            if (owed_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing owed (index %0d, last %0b)",
                                 results, got.color_index, got.last));
                return;
            end
            want = owed_results.pop_front();
            compare_field("color_valid", WORD_W'(got.color_valid),
                          WORD_W'(want.color_valid));
            compare_field("color_index", WORD_W'(got.color_index),
                          WORD_W'(want.color_index));
            compare_field("record_end", WORD_W'(got.record_end),
                          WORD_W'(want.record_end));
            compare_field("record_key", got.record_key, want.record_key);
            compare_field("record_color_count", WORD_W'(got.record_color_count),
                          WORD_W'(want.record_color_count));
            compare_field("bin_count", WORD_W'(got.bin_count), WORD_W'(want.bin_count));
            compare_field("last", WORD_W'(got.last), WORD_W'(want.last));
        endtask
    endclass

    color_expand_tracker tracker = new();

    color_bitmap_expand_histogram u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_push               (i_push),
        .o_full               (o_full),
        .i_operation          (i_operation),
        .i_data_word          (i_data_word),
        .i_bin_index          (i_bin_index),
        .o_empty              (o_empty),
        .i_pop                (i_pop),
        .o_color_valid        (o_color_valid),
        .o_color_index        (o_color_index),
        .o_record_end         (o_record_end),
        .o_record_key         (o_record_key),
        .o_record_color_count (o_record_color_count),
        .o_bin_count          (o_bin_count),
        .o_last               (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mix of empty, single-bit, sparse, dense and full bitmap words
    function automatic logic [WORD_W-1:0] draw_bitmap();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3:    return 64'd1 << $urandom_range(0, 63);
            4:       return '1;
            5, 6:    return rand64() & rand64() & rand64();
            default: return rand64();
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic op, input logic [WORD_W-1:0] w,
                             input logic [BIN_IDX_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_operation <= op;
        i_data_word <= w;
        i_bin_index <= b;
        @(posedge i_clk);
        while (o_full !== 1'b0) @(posedge i_clk);
        tracker.note_item(op, w, b);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (tracker.owed_results.size() != 0) @(negedge i_clk);
        // key words and blank bitmap words may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_color_words(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.color_words = v;
        tracker.cfg_writes++;
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] cfg);
        steady = ($urandom_range(0, 3) == 0);
        set_color_words(cfg);
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 6) == 0)
                send_item(OP_READ, rand64(), $urandom_range(0, 1) ?
                          BIN_IDX_W'($urandom_range(0, 80)) :
                          BIN_IDX_W'($urandom_range(0, 2047)));
            else if (tracker.word_pos == 0)
                send_item(OP_WORD, rand64(), BIN_IDX_W'($urandom));
            else
                send_item(OP_WORD, draw_bitmap(), BIN_IDX_W'($urandom));
        end
        // phases may end mid-record, so the next setting lands inside it
        wait_drained();
    endtask

    initial begin : result_sink
        int      gap;
        t_result got;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty !== 1'b0) @(posedge i_clk);
            got.color_valid        = o_color_valid;
            got.color_index        = o_color_index;
            got.record_end         = o_record_end;
            got.record_key         = o_record_key;
            got.record_color_count = o_record_color_count;
            got.bin_count          = o_bin_count;
            got.last               = o_last;
            tracker.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, tracker.owed_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_push      = 1'b0;
        i_operation = OP_WORD;
        i_data_word = '0;
        i_bin_index = '0;
        steady      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero setting behaves as one bitmap word per record
        set_color_words(5'd0);
        send_item(OP_READ, '0, 11'd0);
        send_item(OP_READ, '1, 11'd2047);            // past the last bin
        send_item(OP_WORD, '1, '0);                  // key
        send_item(OP_WORD, '0, '0);                  // empty record
        send_item(OP_WORD, '0, '1);                  // key
        send_item(OP_WORD, '1, '0);                  // all 64 colors
        send_item(OP_WORD, rand64(), '0);            // key
        send_item(OP_WORD, 64'h8000_0000_0000_0001, '0);
        send_item(OP_READ, '0, 11'd0);
        send_item(OP_READ, '0, 11'd64);
        send_item(OP_READ, '0, 11'd2);
        wait_drained();

        // oversized setting clamps to the maximum; full record hits the top bin
        set_color_words(5'd31);
        send_item(OP_WORD, rand64(), '0);
        repeat (MAX_WORDS) send_item(OP_WORD, '1, '0);
        send_item(OP_READ, '0, BIN_IDX_W'(NUM_BINS - 1));
        // blank words mid-record, then the record is shortened under it
        send_item(OP_WORD, rand64(), '0);
        send_item(OP_WORD, '0, '0);
        send_item(OP_WORD, '0, '0);
        wait_drained();
        set_color_words(5'd2);
        send_item(OP_WORD, 64'h20, '0);
        wait_drained();

        run_random_phase(5'd3);
        run_random_phase(5'd16);
        run_random_phase(5'd1);
        run_random_phase(5'd0);
        run_random_phase(5'd2);
        run_random_phase(CFG_W'($urandom_range(0, 31)));

        $display("covered %0d items (%0d records closed, %0d bin reads), %0d results checked",
                 tracker.items, tracker.records, tracker.reads, tracker.results);
        $display("over %0d color_words settings in %0d cycles, %0d mismatches",
                 tracker.cfg_writes, cycle_count, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
